### hw/rtl/dda_pkg.sv
// Shared types and constants of the DDA line rasterizer.
// Holds the controller/datapath command and status structs, the clip window
// struct and the register map. No dependencies.
package dda_pkg;

  localparam int COORD_W = 16;
  localparam int MAXY_W  = 15;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [1:0] REG_CLIP_MIN_X = 2'd0;
  localparam logic [1:0] REG_CLIP_MAX_X = 2'd1;
  localparam logic [1:0] REG_CLIP_MAX_Y = 2'd2;

  localparam logic signed [COORD_W-1:0] CLIP_MIN_X_RST = 16'sd0;
  localparam logic signed [COORD_W-1:0] CLIP_MAX_X_RST = 16'sd1919;
  localparam logic [MAXY_W-1:0]         CLIP_MAX_Y_RST = 15'd1079;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic [MAXY_W-1:0]         max_y;
  } dda_clip_t;

  typedef struct packed {
    logic capture;
    logic delta;
    logic span;
    logic div_init;
    logic div_step;
    logic step_load;
    logic emit;
    logic reject;
  } dda_cmd_t;

  typedef struct packed {
    logic reject;
    logic zero_len;
    logic div_last;
    logic last_point;
    logic out_free;
  } dda_status_t;

endpackage

### hw/rtl/dda_cfg_regs.sv
// Clip window registers of the DDA line rasterizer behind an APB-style port.
// Depends on dda_pkg for the register map, reset values and clip struct.
module dda_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dda_pkg::ADDR_W-1:0]  paddr,
  input  logic [dda_pkg::DATA_W-1:0]  pwdata,
  output logic [dda_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output dda_pkg::dda_clip_t          clip
);
  import dda_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      clip.min_x <= CLIP_MIN_X_RST;
      clip.max_x <= CLIP_MAX_X_RST;
      clip.max_y <= CLIP_MAX_Y_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CLIP_MIN_X: clip.min_x <= pwdata[COORD_W-1:0];
        REG_CLIP_MAX_X: clip.max_x <= pwdata[COORD_W-1:0];
        REG_CLIP_MAX_Y: clip.max_y <= pwdata[MAXY_W-1:0];
        default: ;
      endcase
    end
  end

  // Signed registers read back sign-extended.
  always_comb begin
    case (reg_idx)
      REG_CLIP_MIN_X: prdata = {{(DATA_W-COORD_W){clip.min_x[COORD_W-1]}}, clip.min_x};
      REG_CLIP_MAX_X: prdata = {{(DATA_W-COORD_W){clip.max_x[COORD_W-1]}}, clip.max_x};
      REG_CLIP_MAX_Y: prdata = {{(DATA_W-MAXY_W){1'b0}}, clip.max_y};
      default:        prdata = '0;
    endcase
  end

endmodule

### hw/rtl/dda_ctrl.sv
// Sequencing state machine of the DDA line rasterizer.
// Depends on dda_pkg for the command and status structs.
module dda_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dda_pkg::dda_status_t status,
  output dda_pkg::dda_cmd_t    cmd
);
  import dda_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELTA = 3'd1;
  localparam logic [2:0] S_SPAN  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_REJ   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_STEP  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = S_SPAN;
      end
      S_SPAN: begin
        cmd.span   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.reject) begin
          state_next = S_REJ;
        end else if (status.zero_len) begin
          state_next = S_STEP;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_REJ: begin
        if (status.out_free) begin
          cmd.reject = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step_load = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_point) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.reject) |-> status.out_free)
    else $error("output register loaded while a result is still held");

  a_accept_starts_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_DELTA))
    else $error("accepted item did not start the line setup");
`endif

endmodule

### hw/rtl/dda_datapath.sv
// Datapath of the DDA line rasterizer: endpoint capture, span check,
// bit-serial step divider, position accumulators and the output register.
// Depends on dda_pkg for the command, status and clip structs.
module dda_datapath #(
  parameter int MAX_SPAN  = 63,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dda_pkg::dda_cmd_t                   cmd,
  output dda_pkg::dda_status_t                status,
  input  dda_pkg::dda_clip_t                  clip,
  input  logic signed [dda_pkg::COORD_W-1:0]  start_x,
  input  logic signed [dda_pkg::COORD_W-1:0]  start_y,
  input  logic signed [dda_pkg::COORD_W-1:0]  end_x,
  input  logic signed [dda_pkg::COORD_W-1:0]  end_y,
  input  logic                                thick,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dda_pkg::COORD_W-1:0]  pixel_x,
  output logic signed [dda_pkg::COORD_W-1:0]  pixel_y,
  output logic                                visible,
  output logic                                fat_point,
  output logic                                last,
  output logic                                rejected
);
  import dda_pkg::*;

  localparam int SW     = $clog2(MAX_SPAN + 1);
  localparam int PL_W   = $clog2(MAX_SPAN + 2);
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int POS_W  = COORD_W + 1 + FRAC_BITS;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int D_W    = COORD_W + 1;
  localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  // Captured command.
  logic signed [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic                      thick_r;
  // Deltas and span.
  logic signed [D_W-1:0]     dx_r, dy_r;
  logic [D_W-1:0]            ax, ay, span;
  logic [SW-1:0]             ax_r, ay_r, n_r;
  logic                      neg_x, neg_y, reject_r, zero_r;
  // Divider.
  logic [SW:0]               rem_x, rem_y, diff_x, diff_y;
  logic                      ge_x, ge_y;
  logic [FRAC_BITS:0]        q_x, q_y;
  logic [CNT_W-1:0]          div_cnt;
  // Stepping.
  logic signed [STEP_W-1:0]  step_x, step_y;
  logic signed [POS_W-1:0]   pos_x, pos_y;
  logic signed [POS_W-1:0]   lo_x, hi_x, hi_y;
  logic [PL_W-1:0]           points_left;
  logic                      fat_mode;
  logic [COORD_W-1:0]        trunc_x, trunc_y;
  logic                      vis;

  assign ax   = dx_r[D_W-1] ? D_W'(-dx_r) : D_W'(dx_r);
  assign ay   = dy_r[D_W-1] ? D_W'(-dy_r) : D_W'(dy_r);
  assign span = (ax >= ay) ? ax : ay;

  assign diff_x = rem_x - {1'b0, n_r};
  assign diff_y = rem_y - {1'b0, n_r};
  assign ge_x   = (rem_x >= {1'b0, n_r});
  assign ge_y   = (rem_y >= {1'b0, n_r});

  // Truncation toward zero: floor, then one up for a negative value with a fraction.
  assign trunc_x = pos_x[FRAC_BITS+COORD_W-1:FRAC_BITS]
                 + COORD_W'(pos_x[POS_W-1] && (|pos_x[FRAC_BITS-1:0]));
  assign trunc_y = pos_y[FRAC_BITS+COORD_W-1:FRAC_BITS]
                 + COORD_W'(pos_y[POS_W-1] && (|pos_y[FRAC_BITS-1:0]));

  assign lo_x = {clip.min_x[COORD_W-1], clip.min_x, {FRAC_BITS{1'b0}}};
  assign hi_x = {clip.max_x[COORD_W-1], clip.max_x, {FRAC_BITS{1'b0}}};
  assign hi_y = {2'b00, clip.max_y, {FRAC_BITS{1'b0}}};
  assign vis  = (pos_x >= lo_x) && (pos_x <= hi_x) && !pos_y[POS_W-1] && (pos_y <= hi_y);

  assign status.reject     = reject_r;
  assign status.zero_len   = zero_r;
  assign status.div_last   = (div_cnt == CNT_W'(FRAC_BITS));
  assign status.last_point = (points_left == PL_W'(1));
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx_r    <= start_x;
      sy_r    <= start_y;
      ex_r    <= end_x;
      ey_r    <= end_y;
      thick_r <= thick;
    end
    if (cmd.delta) begin
      dx_r <= {ex_r[COORD_W-1], ex_r} - {sx_r[COORD_W-1], sx_r};
      dy_r <= {ey_r[COORD_W-1], ey_r} - {sy_r[COORD_W-1], sy_r};
    end
    if (cmd.span) begin
      ax_r     <= ax[SW-1:0];
      ay_r     <= ay[SW-1:0];
      n_r      <= span[SW-1:0];
      neg_x    <= dx_r[D_W-1];
      neg_y    <= dy_r[D_W-1];
      reject_r <= (span > D_W'(MAX_SPAN));
      zero_r   <= (span == '0);
      pos_x    <= {sx_r[COORD_W-1], sx_r, {FRAC_BITS{1'b0}}};
      pos_y    <= {sy_r[COORD_W-1], sy_r, {FRAC_BITS{1'b0}}};
      fat_mode <= thick_r;
    end
    // Restoring division, one quotient bit per cycle: the integer bit first,
    // then the fraction bits.
    if (cmd.div_init) begin
      rem_x   <= {1'b0, ax_r};
      rem_y   <= {1'b0, ay_r};
      q_x     <= '0;
      q_y     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem_x   <= ge_x ? {diff_x[SW-1:0], 1'b0} : {rem_x[SW-1:0], 1'b0};
      rem_y   <= ge_y ? {diff_y[SW-1:0], 1'b0} : {rem_y[SW-1:0], 1'b0};
      q_x     <= {q_x[FRAC_BITS-1:0], ge_x};
      q_y     <= {q_y[FRAC_BITS-1:0], ge_y};
      div_cnt <= div_cnt + CNT_W'(1);
    end
    if (cmd.step_load) begin
      if (zero_r) begin
        step_x <= '0;
        step_y <= '0;
      end else begin
        step_x <= neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
        step_y <= neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
      end
    end
    if (cmd.emit) begin
      pos_x <= pos_x + {{(POS_W-STEP_W){step_x[STEP_W-1]}}, step_x};
      pos_y <= pos_y + {{(POS_W-STEP_W){step_y[STEP_W-1]}}, step_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_left <= '0;
    end else if (cmd.span) begin
      points_left <= span[PL_W-1:0] + PL_W'(1);
    end else if (cmd.emit) begin
      points_left <= points_left - PL_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.reject) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x   <= trunc_x;
      pixel_y   <= trunc_y;
      visible   <= vis;
      fat_point <= fat_mode;
      last      <= (points_left == PL_W'(1));
      rejected  <= 1'b0;
    end else if (cmd.reject) begin
      pixel_x   <= '0;
      pixel_y   <= '0;
      visible   <= 1'b0;
      fat_point <= 1'b0;
      last      <= 1'b1;
      rejected  <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_emit_has_points: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (points_left != '0))
    else $error("point emitted with no points left");

  a_step_within_one: assert property (@(posedge clk) disable iff (rst)
    (cmd.step_load && !zero_r) |-> (q_x <= ONE_Q && q_y <= ONE_Q))
    else $error("step magnitude above one pixel");
`endif

endmodule

### hw/rtl/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer.
// Depends on dda_pkg, dda_cfg_regs, dda_ctrl and dda_datapath.
//
// Usage: one input item is a line command (start_x, start_y, end_x, end_y,
// thick), taken at a rising edge with in_valid high and in_stall low. The
// span n is the larger absolute delta; the block emits n + 1 point items on
// the output channel, one per cycle while out_stall is low, each with its
// truncated pixel position, a clip visibility flag, the thick flag and a
// last marker. A span above MAX_SPAN gives a single item with rejected and
// last set. The clip window is to be written through the APB-style port only
// while the block is idle, which the block itself does not enforce; pready is
// always high. Sequence: after the accept, setup states form the deltas and
// span and check it, then the bit-serial step divider forms the quotients,
// one quotient bit per cycle with the integer bit first, and a step state
// turns them into signed steps before the points are emitted. A zero-length
// line skips the divider, a rejected line the divider and the stepping. One
// line is worked on at a time; the next command is accepted while the last
// point still waits in the output register. A stall from the receiver holds
// the output register and pauses point emission. Synchronous reset restores
// the clip window to 0..1919 by 0..1079 and empties the output register.
module dda_line_rasterizer #(
  parameter int MAX_SPAN  = 63,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dda_pkg::ADDR_W-1:0]          paddr,
  input  logic [dda_pkg::DATA_W-1:0]          pwdata,
  output logic [dda_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  // Line command channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [dda_pkg::COORD_W-1:0]  start_x,
  input  logic signed [dda_pkg::COORD_W-1:0]  start_y,
  input  logic signed [dda_pkg::COORD_W-1:0]  end_x,
  input  logic signed [dda_pkg::COORD_W-1:0]  end_y,
  input  logic                                thick,
  // Point channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dda_pkg::COORD_W-1:0]  pixel_x,
  output logic signed [dda_pkg::COORD_W-1:0]  pixel_y,
  output logic                                visible,
  output logic                                fat_point,
  output logic                                last,
  output logic                                rejected
);
  import dda_pkg::*;

  dda_clip_t   clip;
  dda_cmd_t    cmd;
  dda_status_t status;

  // Clip window registers.
  dda_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .clip    (clip)
  );

  // Sequencer: accepts a command, walks setup, division and emission.
  dda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and the output register.
  dda_datapath #(
    .MAX_SPAN  (MAX_SPAN),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .clip      (clip),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .thick     (thick),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .visible   (visible),
    .fat_point (fat_point),
    .last      (last),
    .rejected  (rejected)
  );

endmodule

### bench/tb.sv
// Self-checking bench for the DDA line rasterizer: line commands in, points out.
// Depends on dda_pkg and dda_line_rasterizer; checks every point against a table
// row or the fixed-point stepping predictor; both channels idle, stall at random.
module tb;
  import dda_pkg::*;

  localparam int MAX_SPAN  = 63;
  localparam int FRAC_BITS = 16;
  localparam longint ONE   = longint'(1) << FRAC_BITS;

  // A correct run never goes this long without an item moving on either channel.
  // The worst gap is one full line setup plus a long receiver stall.
  localparam int QUIET_LIMIT = 4000;
  // Cycles we keep watching after the last expected point, about one longest line.
  localparam int TAIL_CYCLES = 120;
  localparam int RANDOM_PER_WINDOW = 58;
  localparam int WINDOWS = 6;
  localparam int MAX_PRINTS = 30;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic                      th;
  } line_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      vis;
    logic                      fat;
    logic                      lst;
    logic                      rej;
  } point_t;

  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

  // Columns of the directed table. Rows with TYPED set carry the single point
  // they produce; the others are checked against the predictor.
  localparam int C_SX = 0, C_SY = 1, C_EX = 2, C_EY = 3, C_TH = 4, C_TYPED = 5;
  localparam int C_PX = 6, C_PY = 7, C_VIS = 8, C_FAT = 9, C_LST = 10, C_REJ = 11;
  localparam int DIR_ROWS = 24;

  localparam int DIR_TAB [DIR_ROWS][12] = '{
    // Zero-length lines on and just outside each edge of the reset window.
    '{0, 0, 0, 0, 0,              1, 0, 0, 1, 0, 1, 0},
    '{1919, 1079, 1919, 1079, 1,  1, 1919, 1079, 1, 1, 1, 0},
    '{1920, 5, 1920, 5, 0,        1, 1920, 5, 0, 0, 1, 0},
    '{-1, 5, -1, 5, 0,            1, -1, 5, 0, 0, 1, 0},
    '{5, -1, 5, -1, 1,            1, 5, -1, 0, 1, 1, 0},
    '{5, 1080, 5, 1080, 0,        1, 5, 1080, 0, 0, 1, 0},
    // Spans just over the limit and the widest possible spans are rejected.
    '{0, 0, 64, 0, 0,             1, 0, 0, 0, 0, 1, 1},
    '{0, 0, 3, -64, 1,            1, 0, 0, 0, 0, 1, 1},
    '{-32768, -32768, 32767, 32767, 1, 1, 0, 0, 0, 0, 1, 1},
    '{32767, -32768, -32768, 32767, 0, 1, 0, 0, 0, 0, 1, 1},
    // Zero-length lines at the coordinate extremes.
    '{-32768, 0, -32768, 0, 1,    1, -32768, 0, 0, 1, 1, 0},
    '{32767, 32767, 32767, 32767, 0, 1, 32767, 32767, 0, 0, 1, 0},
    // Longest legal lines, six octants, fractional steps and clip crossings.
    '{0, 0, 63, 0, 0,             0, 0, 0, 0, 0, 0, 0},
    '{1919, 1079, 1856, 1016, 1,  0, 0, 0, 0, 0, 0, 0},
    '{10, 10, 13, 50, 0,          0, 0, 0, 0, 0, 0, 0},
    '{100, 500, 37, 510, 1,       0, 0, 0, 0, 0, 0, 0},
    '{-20, -20, 20, 20, 0,        0, 0, 0, 0, 0, 0, 0},
    '{1900, 1070, 1940, 1100, 0,  0, 0, 0, 0, 0, 0, 0},
    '{-32768, -32768, -32705, -32740, 1, 0, 0, 0, 0, 0, 0, 0},
    '{32767, 32767, 32704, 32760, 0, 0, 0, 0, 0, 0, 0, 0},
    '{5, 5, 6, 5, 0,              0, 0, 0, 0, 0, 0, 0},
    '{7, 3, 4, 40, 1,             0, 0, 0, 0, 0, 0, 0},
    '{0, 0, -63, -63, 0,          0, 0, 0, 0, 0, 0, 0},
    '{-5, -5, -8, -40, 0,         0, 0, 0, 0, 0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [ADDR_W-1:0]         paddr   = '0;
  logic [DATA_W-1:0]         pwdata  = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] start_x  = '0;
  logic signed [COORD_W-1:0] start_y  = '0;
  logic signed [COORD_W-1:0] end_x    = '0;
  logic signed [COORD_W-1:0] end_y    = '0;
  logic                      thick    = 1'b0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] pixel_x;
  logic signed [COORD_W-1:0] pixel_y;
  logic                      visible;
  logic                      fat_point;
  logic                      last;
  logic                      rejected;

  // Local copy of the clip window, as last written through the register port.
  logic signed [COORD_W-1:0] win_min_x = CLIP_MIN_X_RST;
  logic signed [COORD_W-1:0] win_max_x = CLIP_MAX_X_RST;
  logic [MAXY_W-1:0]         win_max_y = CLIP_MAX_Y_RST;

  // Points the block still owes us, oldest first.
  point_t pending_points [$];
  int     bad_count   = 0;
  int     point_count = 0;
  int     quiet_cycles = 0;
  int     burst_left  = 0;

  rx_mode_t rx_mode = RX_FLOW;
  int       rx_left = 0;

  dda_line_rasterizer #(
    .MAX_SPAN (MAX_SPAN),
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .thick    (thick),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .visible  (visible),
    .fat_point(fat_point),
    .last     (last),
    .rejected (rejected)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Walks one line the way the block does: both steps are delta / span in
  // Q16.16, truncated toward zero, and every point is checked against the clip
  // window on its exact fixed-point position before the step is added.
  function automatic void trace_line(input line_t l);
    longint dx, dy, ax, ay, n, stx, sty, fx, fy, lo_x, hi_x, hi_y;
    point_t p;
    dx = longint'(l.ex) - longint'(l.sx);
    dy = longint'(l.ey) - longint'(l.sy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    n  = (ax >= ay) ? ax : ay;
    if (n > MAX_SPAN) begin
      // Too long to draw: a single rejected item with everything else cleared.
      p = '0;
      p.lst = 1'b1;
      p.rej = 1'b1;
      pending_points.push_back(p);
      return;
    end
    // A zero-length line has no direction, so it steps by nothing.
    stx  = (n == 0) ? 0 : (dx * ONE) / n;
    sty  = (n == 0) ? 0 : (dy * ONE) / n;
    fx   = longint'(l.sx) * ONE;
    fy   = longint'(l.sy) * ONE;
    lo_x = longint'(win_min_x) * ONE;
    hi_x = longint'(win_max_x) * ONE;
    hi_y = longint'(win_max_y) * ONE;
    for (longint k = 0; k <= n; k++) begin
      p.px  = COORD_W'(fx / ONE);
      p.py  = COORD_W'(fy / ONE);
      p.vis = (lo_x <= fx) && (fx <= hi_x) && (fy >= 0) && (fy <= hi_y);
      p.fat = l.th;
      p.lst = (k == n);
      p.rej = 1'b0;
      pending_points.push_back(p);
      fx += stx;
      fy += sty;
    end
  endfunction

  // Builds a random line command. Most are drawable lines placed around the
  // current clip window so that both visible and clipped points show up; the
  // rest are drawable lines anywhere, spans right at the limit, and pure noise.
  function automatic line_t make_line();
    line_t l;
    int kind, n, sx, sy, maj, mnr, ddx, ddy;
    kind = $urandom_range(0, 99);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(0, MAX_SPAN);
    if (kind < 70) begin
      case ($urandom_range(0, 2))
        0:       sx = int'(win_min_x);
        1:       sx = int'(win_max_x);
        default: sx = (int'(win_min_x) + int'(win_max_x)) / 2;
      endcase
      sx += int'($urandom_range(0, 140)) - 70;
      sy = ($urandom_range(0, 1) ? 0 : int'(win_max_y)) + int'($urandom_range(0, 140)) - 70;
    end else begin
      sx = $urandom;
      sy = $urandom;
      if (kind >= 95)
        n = $urandom_range(MAX_SPAN, MAX_SPAN + 1);
    end
    maj = $urandom_range(0, 1) ? n : -n;
    mnr = int'($urandom_range(0, 2 * n)) - n;
    if ($urandom_range(0, 1)) begin
      ddx = maj;
      ddy = mnr;
    end else begin
      ddx = mnr;
      ddy = maj;
    end
    l.sx = COORD_W'(sx);
    l.sy = COORD_W'(sy);
    l.ex = COORD_W'(sx + ddx);
    l.ey = COORD_W'(sy + ddy);
    if (kind >= 85 && kind < 95) begin
      l.ex = COORD_W'($urandom);
      l.ey = COORD_W'($urandom);
    end
    l.th = 1'($urandom_range(0, 1));
    return l;
  endfunction

  // Presents one line command and waits for it to be taken. The expected
  // points are recorded at the accepting edge. The sender works in bursts:
  // valid stays high across the items of a burst, then drops for a short gap.
  task automatic send_line(input line_t l, input bit typed, input point_t want);
    int gap;
    in_valid <= 1'b1;
    start_x  <= l.sx;
    start_y  <= l.sy;
    end_x    <= l.ex;
    end_y    <= l.ey;
    thick    <= l.th;
    do @(posedge clk); while (in_stall);
    if (typed)
      pending_points.push_back(want);
    else
      trace_line(l);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender back until every point owed has come out.
  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write: a setup phase, then an access phase that completes on
  // pready. The port then rests with psel low so psel can rise again cleanly.
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic signed [COORD_W-1:0] mn,
                            input logic signed [COORD_W-1:0] mx,
                            input logic [MAXY_W-1:0] my);
    write_reg(REG_CLIP_MIN_X, DATA_W'(mn));
    write_reg(REG_CLIP_MAX_X, DATA_W'(mx));
    write_reg(REG_CLIP_MAX_Y, {{(DATA_W - MAXY_W){1'b0}}, my});
    win_min_x = mn;
    win_max_x = mx;
    win_max_y = my;
  endtask

  task automatic flag_point(input string what, input int got, input int want);
    if (bad_count < MAX_PRINTS)
      $display("point %0d: %s is %0d, expected %0d", point_count, what, got, want);
    bad_count++;
  endtask

  // The receiver switches between flowing freely, light and heavy random
  // stalls, and a fixed beat, picking a new mode at random as each one runs out.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(64, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FLOW:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= ((rx_left % 8) < 5);
    endcase
  end

  // Every point taken by the receiver is compared with the oldest one owed.
  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        flag_point("unexpected point, x", int'(pixel_x), 0);
      end else begin
        want = pending_points.pop_front();
        if (pixel_x !== want.px)   flag_point("pixel_x", int'(pixel_x), int'(want.px));
        if (pixel_y !== want.py)   flag_point("pixel_y", int'(pixel_y), int'(want.py));
        if (visible !== want.vis)  flag_point("visible", int'(visible), int'(want.vis));
        if (fat_point !== want.fat) flag_point("fat_point", int'(fat_point), int'(want.fat));
        if (last !== want.lst)     flag_point("last", int'(last), int'(want.lst));
        if (rejected !== want.rej) flag_point("rejected", int'(rejected), int'(want.rej));
      end
      point_count++;
    end
  end

  // The run is cut short only if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    line_t  l;
    point_t want;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed lines run against the reset clip window.
    for (int r = 0; r < DIR_ROWS; r++) begin
      l.sx     = COORD_W'(DIR_TAB[r][C_SX]);
      l.sy     = COORD_W'(DIR_TAB[r][C_SY]);
      l.ex     = COORD_W'(DIR_TAB[r][C_EX]);
      l.ey     = COORD_W'(DIR_TAB[r][C_EY]);
      l.th     = DIR_TAB[r][C_TH] != 0;
      want.px  = COORD_W'(DIR_TAB[r][C_PX]);
      want.py  = COORD_W'(DIR_TAB[r][C_PY]);
      want.vis = DIR_TAB[r][C_VIS] != 0;
      want.fat = DIR_TAB[r][C_FAT] != 0;
      want.lst = DIR_TAB[r][C_LST] != 0;
      want.rej = DIR_TAB[r][C_REJ] != 0;
      send_line(l, DIR_TAB[r][C_TYPED] != 0, want);
    end

    // Random lines under a series of clip windows: the full coordinate range,
    // an empty window, a single-pixel window, a random span, the reset window
    // and fully random register values. The block is drained before each write.
    for (int w = 0; w < WINDOWS; w++) begin
      drain();
      case (w)
        0: set_window(16'sh8000, 16'sh7fff, 15'h7fff);
        1: set_window(16'sd500, -16'sd500, MAXY_W'($urandom));
        2: set_window(16'sd0, 16'sd0, 15'd0);
        3: begin
          l.sx = COORD_W'($urandom_range(0, 4000) - 2000);
          set_window(l.sx, COORD_W'(int'(l.sx) + int'($urandom_range(0, 3000))),
                     MAXY_W'($urandom_range(0, 2000)));
        end
        4: set_window(CLIP_MIN_X_RST, CLIP_MAX_X_RST, CLIP_MAX_Y_RST);
        default: set_window(COORD_W'($urandom), COORD_W'($urandom), MAXY_W'($urandom));
      endcase
      for (int i = 0; i < RANDOM_PER_WINDOW; i++) begin
        send_line(make_line(), 1'b0, '0);
        // Now and then the sender waits for the block to empty completely.
        if ($urandom_range(0, 39) == 0)
          drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_count == 0 && pending_points.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### files.f
hw/rtl/dda_pkg.sv
hw/rtl/dda_cfg_regs.sv
hw/rtl/dda_ctrl.sv
hw/rtl/dda_datapath.sv
hw/rtl/dda_line_rasterizer.sv
bench/tb.sv
